>>> sv/los_pkg.sv
// Shared constants and codes for the linear output scaler.
package los_pkg;

  localparam int OUT_WIDTH_DEF     = 11;
  localparam int LOW_PART_BITS_DEF = 3;

  localparam int SAMPLE_W   = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 3;

  // Reset values and write mask of the configuration registers
  localparam logic [SAMPLE_W-1:0]   IN_LOW_RST   = 16'sh0000;
  localparam logic [SAMPLE_W-1:0]   IN_HIGH_RST  = 16'sh7FFF;
  localparam logic [CFG_DATA_W-1:0] OUT_LOW_RST  = 16'h0000;
  localparam logic [CFG_DATA_W-1:0] OUT_HIGH_RST = 16'h07FF;
  localparam logic [CFG_DATA_W-1:0] CODE_MASK    = 16'h07FF;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_IN_LOW     = 3'd0,
    REG_IN_HIGH    = 3'd1,
    REG_OUT_LOW    = 3'd2,
    REG_OUT_HIGH   = 3'd3,
    REG_ZERO_BASED = 3'd4,
    REG_CAL_MODE   = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CAL_NORMAL    = 2'd0,
    CAL_FORCE_LOW = 2'd1,
    CAL_FORCE_HI  = 2'd2,
    CAL_HOLD      = 2'd3
  } cal_mode_t;

  // Which end of the scaling curve an item falls on, or whether it is interpolated
  typedef enum logic [1:0] {
    SEL_BOTTOM = 2'd0,
    SEL_TOP    = 2'd1,
    SEL_INTERP = 2'd2
  } seg_sel_t;

endpackage

>>> sv/linear_output_scaler.sv
// Linear output scaler: pipelined two-point scaling with clamp and calibration modes.
//
// Usage
//   Input request: in_sample on in_valid/in_ready. Result request: out_code,
//   out_code_high and out_code_low on out_valid/out_ready. One result per sample,
//   in order. Configuration via cfg_we/cfg_addr/cfg_wdata, written while idle.
// Throughput and structure
//   One sample per clock while out_ready is high. A restoring divider
//   resolves one quotient bit per stage over OUT_WIDTH+1 stages, after three
//   stages of range check, span and multiply, and ahead of the output register.
// Reset
//   rst_n (synchronous, active low) empties the pipeline, loads the register
//   defaults and clears the hold value to 0.
// Stall
//   Each stage loads when it is empty or its contents move on, so bubbles
//   close up while out_ready is low; once every stage holds a request,
//   in_ready drops. Nothing is lost or repeated.
module linear_output_scaler
  import los_pkg::*;
#(
  parameter int OUT_WIDTH     = OUT_WIDTH_DEF,
  parameter int LOW_PART_BITS = LOW_PART_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [SAMPLE_W-1:0]      in_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [OUT_WIDTH-1:0]            out_code,
  output logic [OUT_WIDTH-LOW_PART_BITS-1:0] out_code_high,
  output logic [LOW_PART_BITS-1:0]        out_code_low,
  input  logic                            cfg_we,
  input  logic [CFG_ADDR_W-1:0]           cfg_addr,
  input  logic [CFG_DATA_W-1:0]           cfg_wdata
);

  // Quotient bits: |top - bottom| < 2^(OUT_WIDTH+1)
  localparam int QW = OUT_WIDTH + 1;
  // Signed width holding bottom, span and signed quotient
  localparam int BW = OUT_WIDTH + 2;
  // Width of 5*out_low - out_high
  localparam int XW = OUT_WIDTH + 4;
  // Product magnitude: (sample - in_low) < 2^16 times span < 2^QW
  localparam int PW = SAMPLE_W + QW;
  // Stages: range check, span, multiply, QW divide steps, output
  localparam int NS = QW + 4;
  localparam int ST_SPAN = 1;
  localparam int ST_MUL  = 2;
  localparam int ST_OUT  = NS - 1;
  localparam logic [OUT_WIDTH-1:0] CODE_MAX = '1;

  typedef struct packed {
    seg_sel_t              sel;
    logic signed [BW-1:0]  bottom;
    logic [SAMPLE_W-1:0]   offs;   // sample - in_low
    logic [SAMPLE_W-1:0]   den;    // in_high - in_low
  } rng_t;

  typedef struct packed {
    seg_sel_t              sel;
    logic signed [BW-1:0]  bottom;
    logic [SAMPLE_W-1:0]   offs;
    logic [SAMPLE_W-1:0]   den;
    logic                  neg;
    logic [QW-1:0]         mag;    // |top - bottom|
  } spn_t;

  typedef struct packed {
    seg_sel_t              sel;
    logic signed [BW-1:0]  bottom;
    logic [SAMPLE_W-1:0]   den;
    logic                  neg;
    logic [PW-1:0]         rem;
    logic [QW-1:0]         quo;
  } div_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] in_low_r, in_high_r;
  logic [OUT_WIDTH-1:0]       out_low_r, out_high_r;
  logic                       zero_based_r;
  cal_mode_t                  cal_mode_r;
  logic [OUT_WIDTH-1:0]       wr_code;

  // Codes are masked to the 11-bit field as written
  assign wr_code = cfg_wdata[OUT_WIDTH-1:0] & CODE_MASK[OUT_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_low_r     <= IN_LOW_RST;
      in_high_r    <= IN_HIGH_RST;
      out_low_r    <= OUT_LOW_RST[OUT_WIDTH-1:0];
      out_high_r   <= OUT_HIGH_RST[OUT_WIDTH-1:0];
      zero_based_r <= 1'b0;
      cal_mode_r   <= CAL_NORMAL;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_IN_LOW:     in_low_r     <= cfg_wdata[SAMPLE_W-1:0];
        REG_IN_HIGH:    in_high_r    <= cfg_wdata[SAMPLE_W-1:0];
        REG_OUT_LOW:    out_low_r    <= wr_code;
        REG_OUT_HIGH:   out_high_r   <= wr_code;
        REG_ZERO_BASED: zero_based_r <= cfg_wdata[0];
        REG_CAL_MODE:   cal_mode_r   <= cal_mode_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: a stage loads when empty or when its contents leave
  // ---------------------------------------------------------------------------
  logic [NS-1:0] vld_r;
  logic [NS:0]   take;

  always_comb begin
    take[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      take[k] = !vld_r[k] || take[k+1];
    end
  end

  assign in_ready  = take[0];
  assign out_valid = vld_r[ST_OUT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (take[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (take[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: bottom code, range test, offset and denominator
  // ---------------------------------------------------------------------------
  rng_t rng_r, rng_nxt;

  always_comb begin
    logic signed [XW-1:0]         five_lo;
    logic signed [XW-1:0]         five_lo_rnd;
    logic signed [XW-1:0]         live_zero;
    logic signed [SAMPLE_W:0]     offs_w;
    logic signed [SAMPLE_W:0]     den_w;
    // live zero = trunc((5*out_low - out_high) / 4)
    five_lo = $signed({4'b0, out_low_r}) + $signed({2'b0, out_low_r, 2'b0})
              - $signed({4'b0, out_high_r});
    five_lo_rnd = five_lo[XW-1] ? five_lo + XW'(3) : five_lo;
    live_zero   = five_lo_rnd >>> 2;
    offs_w = {in_sample[SAMPLE_W-1], in_sample} - {in_low_r[SAMPLE_W-1], in_low_r};
    den_w  = {in_high_r[SAMPLE_W-1], in_high_r} - {in_low_r[SAMPLE_W-1], in_low_r};

    rng_nxt.bottom = zero_based_r ? $signed({2'b0, out_low_r}) : live_zero[BW-1:0];
    if (in_sample <= in_low_r) begin
      rng_nxt.sel = SEL_BOTTOM;
    end else if (in_sample >= in_high_r) begin
      rng_nxt.sel = SEL_TOP;
    end else begin
      rng_nxt.sel = SEL_INTERP;
    end
    rng_nxt.offs = offs_w[SAMPLE_W-1:0];
    rng_nxt.den  = den_w[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (take[0]) begin
      rng_r <= rng_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: span top - bottom as sign and magnitude
  // ---------------------------------------------------------------------------
  spn_t spn_r, spn_nxt;

  always_comb begin
    logic signed [BW-1:0] span;
    logic signed [BW-1:0] span_abs;
    span     = $signed({2'b0, out_high_r}) - rng_r.bottom;
    span_abs = span[BW-1] ? -span : span;
    spn_nxt.sel    = rng_r.sel;
    spn_nxt.bottom = rng_r.bottom;
    spn_nxt.offs   = rng_r.offs;
    spn_nxt.den    = rng_r.den;
    spn_nxt.neg    = span[BW-1];
    spn_nxt.mag    = span_abs[QW-1:0];
  end

  always_ff @(posedge clk) begin
    if (take[ST_SPAN]) begin
      spn_r <= spn_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: product magnitude, seeds the divider
  // ---------------------------------------------------------------------------
  div_t mul_r, mul_nxt;

  always_comb begin
    mul_nxt.sel    = spn_r.sel;
    mul_nxt.bottom = spn_r.bottom;
    mul_nxt.den    = spn_r.den;
    mul_nxt.neg    = spn_r.neg;
    mul_nxt.rem    = PW'(spn_r.offs) * PW'(spn_r.mag);
    mul_nxt.quo    = '0;
  end

  always_ff @(posedge clk) begin
    if (take[ST_MUL]) begin
      mul_r <= mul_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Restoring divider, one quotient bit per stage, MSB first.
  // offs < den, so the product is below den * 2^QW and QW bits suffice.
  // ---------------------------------------------------------------------------
  div_t dv_r [QW];

  for (genvar gi = 0; gi < QW; gi++) begin : g_div
    localparam int BIT = QW - 1 - gi;
    div_t dv_in, dv_nxt;

    assign dv_in = (gi == 0) ? mul_r : dv_r[(gi == 0) ? 0 : gi - 1];

    always_comb begin
      logic [PW-1:0] trial;
      trial  = PW'(dv_in.den) << BIT;
      dv_nxt = dv_in;
      if (dv_in.rem >= trial) begin
        dv_nxt.rem      = dv_in.rem - trial;
        dv_nxt.quo[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (take[ST_MUL + 1 + gi]) begin
        dv_r[gi] <= dv_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: sign, offset, clamp, calibration override
  // ---------------------------------------------------------------------------
  logic [OUT_WIDTH-1:0] code_r, code_nxt;
  logic [OUT_WIDTH-1:0] last_r;
  div_t                 dv_last;

  assign dv_last = dv_r[QW-1];

  always_comb begin
    logic signed [BW-1:0] quo_s;
    logic signed [BW:0]   res;
    logic [OUT_WIDTH-1:0] scaled;
    quo_s = $signed({1'b0, dv_last.quo});
    if (dv_last.neg) begin
      quo_s = -quo_s;
    end
    unique case (dv_last.sel)
      SEL_BOTTOM: res = {dv_last.bottom[BW-1], dv_last.bottom};
      SEL_TOP:    res = $signed({3'b0, out_high_r});
      SEL_INTERP: res = {quo_s[BW-1], quo_s} + {dv_last.bottom[BW-1], dv_last.bottom};
      default:    res = $signed({3'b0, out_high_r});
    endcase
    // floor at 1, saturate at full scale
    if (res < $signed((BW+1)'(1))) begin
      scaled = OUT_WIDTH'(1);
    end else if (res > $signed({3'b0, CODE_MAX})) begin
      scaled = CODE_MAX;
    end else begin
      scaled = res[OUT_WIDTH-1:0];
    end
    unique case (cal_mode_r)
      CAL_NORMAL:    code_nxt = scaled;
      CAL_FORCE_LOW: code_nxt = out_low_r;
      CAL_FORCE_HI:  code_nxt = out_high_r;
      CAL_HOLD:      code_nxt = last_r;
      default:       code_nxt = scaled;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take[ST_OUT]) begin
      code_r <= code_nxt;
    end
  end

  // hold value follows every result entering the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
    end else if (take[ST_OUT] && vld_r[ST_OUT-1]) begin
      last_r <= code_nxt;
    end
  end

  assign out_code      = code_r;
  assign out_code_high = code_r[OUT_WIDTH-1:LOW_PART_BITS];
  assign out_code_low  = code_r[LOW_PART_BITS-1:0];

endmodule

>>> tb/linear_output_scaler_test.sv
// Self-checking testbench for the linear output scaler: directed and random requests.
module linear_output_scaler_test;
  import los_pkg::*;

  localparam int OW           = OUT_WIDTH_DEF;
  localparam int LB           = LOW_PART_BITS_DEF;
  localparam int MAX_CODE     = (1 << OW) - 1;
  // Accept-to-result delay of the block; used for settling before writes
  localparam int PIPE_LATENCY = OW + 4;
  // Cycles with no request moving on either side before the run is abandoned
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_OFF_LEN = 300;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic out_valid;
  logic out_ready;
  logic [OW-1:0] out_code;
  logic [OW-LB-1:0] out_code_high;
  logic [LB-1:0] out_code_low;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  linear_output_scaler DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_code     (out_code),
    .out_code_high(out_code_high),
    .out_code_low (out_code_low),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata)
  );

  // One expected result request, with the sample that caused it for messages
  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic [OW-1:0]              code;
    logic [OW-LB-1:0]           code_high;
    logic [LB-1:0]              code_low;
  } code_rec_t;

  code_rec_t pending_codes[$];

  // Shadow copy of the block's registers and hold value
  logic signed [SAMPLE_W-1:0] span_lo;
  logic signed [SAMPLE_W-1:0] span_hi;
  logic [OW-1:0]              code_lo;
  logic [OW-1:0]              code_hi;
  logic                       zero_based;
  cal_mode_t                  cal_sel;
  logic [OW-1:0]              last_code;

  int mismatches;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int quiet_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Two-point scaling with live-zero or zero-based bottom, floor at 1 and saturation,
  // then calibration override. Updates the hold value as the block does.
  function automatic code_rec_t scale_sample(input logic signed [SAMPLE_W-1:0] s);
    code_rec_t rec;
    longint    bottom;
    longint    top;
    longint    r;
    logic [OW-1:0] code;
    top = longint'(code_hi);
    // Signed divide in SV truncates toward zero, as the block does
    if (zero_based) bottom = longint'(code_lo);
    else            bottom = (5 * longint'(code_lo) - top) / 4;
    if (s <= span_lo)      r = bottom;
    else if (s >= span_hi) r = top;
    else r = (longint'(s) - longint'(span_lo)) * (top - bottom) /
             (longint'(span_hi) - longint'(span_lo)) + bottom;
    if (r < 1)        r = 1;
    if (r > MAX_CODE) r = MAX_CODE;
    case (cal_sel)
      CAL_FORCE_LOW: code = code_lo;
      CAL_FORCE_HI:  code = code_hi;
      CAL_HOLD:      code = last_code;
      default:       code = r[OW-1:0];
    endcase
    last_code     = code;
    rec.sample    = s;
    rec.code      = code;
    rec.code_high = code[OW-1:LB];
    rec.code_low  = code[LB-1:0];
    return rec;
  endfunction

  // Offer one sample; called and returns at a falling edge
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid  = 1'b0;
      in_sample = SAMPLE_W'($urandom); // junk while idle
      @(negedge clk);
    end
    in_valid  = 1'b1;
    in_sample = s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_codes.push_back(scale_sample(s));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Wait for every outstanding result, then let the pipe go quiet
  task automatic settle();
    while (pending_codes.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
    cfg_wdata = CFG_DATA_W'($urandom);
    case (idx)
      REG_IN_LOW:     span_lo    = val;
      REG_IN_HIGH:    span_hi    = val;
      REG_OUT_LOW:    code_lo    = val[OW-1:0];
      REG_OUT_HIGH:   code_hi    = val[OW-1:0];
      REG_ZERO_BASED: zero_based = val[0];
      REG_CAL_MODE:   cal_sel    = cal_mode_t'(val[1:0]);
      default: ;
    endcase
  endtask

  task automatic set_scaling(input logic signed [SAMPLE_W-1:0] lo,
                             input logic signed [SAMPLE_W-1:0] hi,
                             input int olo, input int ohi, input logic zb,
                             input cal_mode_t mode);
    settle();
    write_reg(REG_IN_LOW, lo);
    write_reg(REG_IN_HIGH, hi);
    write_reg(REG_OUT_LOW, CFG_DATA_W'(olo));
    write_reg(REG_OUT_HIGH, CFG_DATA_W'(ohi));
    write_reg(REG_ZERO_BASED, {15'd0, zb});
    write_reg(REG_CAL_MODE, {14'd0, mode});
  endtask

  // Random register set; upper bits of narrow registers carry junk
  task automatic apply_random_setup();
    logic signed [SAMPLE_W-1:0] a;
    logic signed [SAMPLE_W-1:0] b;
    logic signed [SAMPLE_W-1:0] t;
    logic [OW-1:0] olo;
    logic [OW-1:0] ohi;
    int            kind;
    int            m;
    cal_mode_t     mode;
    a = SAMPLE_W'($urandom);
    b = SAMPLE_W'($urandom);
    kind = $urandom_range(7);
    if (kind >= 3 && a > b) begin
      t = a; a = b; b = t;
    end
    if (kind == 0) b = a;                                   // empty span
    if (kind == 1 && a < b) begin                           // crossed span
      t = a; a = b; b = t;
    end
    if (kind == 2) b = a + SAMPLE_W'($urandom_range(1, 40)); // narrow span
    if (kind >= 3 && $urandom_range(4) == 0) a = 16'sh8000;
    if (kind >= 3 && $urandom_range(4) == 0) b = 16'sh7FFF;
    olo = OW'($urandom);
    ohi = OW'($urandom);
    if ($urandom_range(5) == 0) olo = ($urandom_range(1) != 0) ? OW'(MAX_CODE) : '0;
    if ($urandom_range(5) == 0) ohi = ($urandom_range(1) != 0) ? OW'(MAX_CODE) : '0;
    m = $urandom_range(9);
    if (m < 7)       mode = CAL_NORMAL;
    else if (m == 7) mode = CAL_FORCE_LOW;
    else if (m == 8) mode = CAL_FORCE_HI;
    else             mode = CAL_HOLD;
    settle();
    write_reg(REG_IN_LOW, a);
    write_reg(REG_IN_HIGH, b);
    write_reg(REG_OUT_LOW, {5'($urandom), olo});
    write_reg(REG_OUT_HIGH, {5'($urandom), ohi});
    write_reg(REG_ZERO_BASED, {15'($urandom), 1'($urandom)});
    write_reg(REG_CAL_MODE, {14'($urandom), mode});
  endtask

  // Samples biased toward the span and its ends
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int lo;
    int hi;
    lo = span_lo;
    hi = span_hi;
    case ($urandom_range(5))
      0, 1: return SAMPLE_W'($urandom);
      2, 3: begin
        if (lo < hi) return SAMPLE_W'(lo + int'($urandom_range(hi - lo)));
        else         return SAMPLE_W'($urandom);
      end
      4:       return SAMPLE_W'(lo + int'($urandom_range(6)) - 3);
      default: return SAMPLE_W'(hi + int'($urandom_range(6)) - 3);
    endcase
  endfunction

  // ---------------- tests ----------------

  // Hold straight after reset gives the cleared hold value
  task automatic test_hold_after_reset();
    write_reg(REG_CAL_MODE, {14'd0, CAL_HOLD});
    send_sample(16'sh1234);
    send_sample(-16'sd77);
  endtask

  // Default registers: live-zero bottom is negative, so the low end floors at 1
  task automatic test_reset_scaling();
    settle();
    write_reg(REG_CAL_MODE, {14'd0, CAL_NORMAL});
    send_sample(16'sh8000);
    send_sample(-16'sd1);
    send_sample(16'sd0);
    send_sample(16'sd1);
    send_sample(16'sd16384);
    send_sample(16'sd32766);
    send_sample(16'sh7FFF);
  endtask

  // Forced codes come out unfloored; hold repeats the last code
  task automatic test_calibration();
    set_scaling(16'sh8000, 16'sh7FFF, 0, MAX_CODE, 1'b1, CAL_FORCE_LOW);
    send_sample(16'sd5);
    settle();
    write_reg(REG_CAL_MODE, {14'd0, CAL_FORCE_HI});
    send_sample(-16'sd5);
    settle();
    write_reg(REG_CAL_MODE, {14'd0, CAL_HOLD});
    send_sample(16'sd0);
    settle();
    write_reg(REG_OUT_HIGH, 16'd0);
    write_reg(REG_CAL_MODE, {14'd0, CAL_FORCE_HI});
    send_sample(16'sd100);
  endtask

  task automatic test_live_zero();
    // bottom above the code range saturates
    set_scaling(-16'sd1000, 16'sd1000, MAX_CODE, 0, 1'b0, CAL_NORMAL);
    send_sample(-16'sd1000);
    // negative bottom: floor at the low end and inside the span
    set_scaling(-16'sd1000, 16'sd1000, 100, 1000, 1'b0, CAL_NORMAL);
    send_sample(-16'sd2000);
    send_sample(-16'sd900);
    send_sample(16'sd333);
    // positive live-zero bottom and plain zero-based interpolation
    set_scaling(16'sd0, 16'sd4000, 400, 1600, 1'b0, CAL_NORMAL);
    send_sample(16'sd1);
    set_scaling(16'sd0, 16'sd4000, 400, 1600, 1'b1, CAL_NORMAL);
    send_sample(16'sd1999);
    send_sample(16'sd3999);
  endtask

  // Empty and crossed spans never interpolate
  task automatic test_crossed_range();
    set_scaling(16'sd500, 16'sd500, 300, 900, 1'b1, CAL_NORMAL);
    send_sample(16'sd500);
    send_sample(16'sd501);
    set_scaling(16'sd800, -16'sd800, 300, 900, 1'b1, CAL_NORMAL);
    send_sample(16'sd0);
    send_sample(16'sd800);
  endtask

  // Receiver holds off long enough for the pipe to fill and stall the input;
  // afterwards the sender waits for every result
  task automatic test_backpressure();
    set_scaling(-16'sd3000, 16'sd9000, 17, 2000, 1'b0, CAL_NORMAL);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = HOLD_OFF_LEN;
    repeat (60) send_sample(pick_sample());
    settle();
  endtask

  // Random traffic under each idling pattern, several register sets each
  task automatic test_random_traffic();
    int idle_pat[4];
    int stall_pat[4];
    idle_pat  = '{0, 68, 0, 35};
    stall_pat = '{0, 0, 68, 35};
    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < 6; k++) begin
        apply_random_setup();
        send_idle_pct  = idle_pat[p];
        recv_stall_pct = stall_pat[p];
        repeat (55) send_sample(pick_sample());
      end
    end
    settle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // ---------------- receiver, checker, watchdog ----------------

  // out_ready: a counted hold-off takes priority over random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    code_rec_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_codes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing pending: code %0d", $realtime, out_code);
      end else begin
        want = pending_codes.pop_front();
        if (out_code !== want.code || out_code_high !== want.code_high ||
            out_code_low !== want.code_low) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: sample %0d: expected code %0d high %0d low %0d, got %0d %0d %0d",
                     $realtime, want.sample, want.code, want.code_high, want.code_low,
                     out_code, out_code_high, out_code_low);
        end
      end
    end
  end

  // Abandon the run if no request moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_sample      = '0;
    out_ready      = 1'b0;
    cfg_we         = 1'b0;
    cfg_addr       = '0;
    cfg_wdata      = '0;
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    quiet_cycles   = 0;
    // shadow registers at their reset values
    span_lo    = IN_LOW_RST;
    span_hi    = IN_HIGH_RST;
    code_lo    = OUT_LOW_RST[OW-1:0];
    code_hi    = OUT_HIGH_RST[OW-1:0];
    zero_based = 1'b0;
    cal_sel    = CAL_NORMAL;
    last_code  = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_hold_after_reset();
    test_reset_scaling();
    test_calibration();
    test_live_zero();
    test_crossed_range();
    test_backpressure();
    test_random_traffic();

    settle();
    repeat (PIPE_LATENCY * 2) @(negedge clk);
    if (mismatches == 0 && pending_codes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
